>>> hdl/qsr_pkg.sv
// Shared record layout and field widths for the record sorter.
package qsr_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned PAY_W = 8;
  localparam int unsigned REC_W = KEY_W + PAY_W;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic        [PAY_W-1:0] payload;
  } rec_t;

endpackage

>>> hdl/qsr_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module qsr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/quick_sort_records.sv
// Top level of the record sorter: load, in-memory quicksort and ordered emission.
//
// Records are taken one per cycle while busy is low; a record arriving with
// the store full is dropped and flags truncated_o on every result of the batch.
// The request flagged last starts the sort, and busy falls as the final sorted
// record is presented. All records live in one synchronous RAM with a single
// read port, and that port sets the sort time: each key comparison needs one
// read, and every partitioned range adds the stack pop, pivot fetch, pivot
// placement and the two pushes. Input that is already ordered is the slowest
// case. Emission then delivers one record per cycle, strobe_o high for exactly
// one cycle per record, with each record read in the cycle before its strobe;
// the receiver cannot stall it. No clearing pass follows reset.
module quick_sort_records #(
  parameter int unsigned N = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [31:0]       key_i,
  input  logic        [7:0]        payload_i,
  input  logic                     last_i,
  output logic                     strobe_o,
  output logic signed [31:0]       key_res_o,
  output logic        [7:0]        payload_res_o,
  output logic                     last_res_o,
  output logic                     truncated_o
);

  localparam int unsigned IW = $clog2(N);
  localparam int unsigned CW = $clog2(N + 1);
  localparam int unsigned SW = 2 * IW;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_POP,
    ST_POPW,
    ST_PIV,
    ST_SCANB,
    ST_SCANA,
    ST_PLACE,
    ST_PUSHR,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] sp_q, sp_d;
  logic          ovf_q, ovf_d;
  logic [IW-1:0] lo_q, lo_d, hi_q, hi_d, a_q, a_d, b_q, b_d, idx_q, idx_d;
  qsr_pkg::rec_t piv_q, piv_d;
  logic          strobe_q, strobe_d, last_q, last_d, trunc_q, trunc_d;

  logic                        s_we;
  logic [IW-1:0]               s_waddr, s_raddr;
  logic [qsr_pkg::REC_W-1:0]   s_wdata, s_rdata;
  logic                        k_we;
  logic [IW-1:0]               k_waddr, k_raddr;
  logic [SW-1:0]               k_wdata, k_rdata;

  qsr_pkg::rec_t rd_rec;
  logic [CW-1:0] cnt_m1, sp_m1;
  logic          left_ok, right_ok;

  qsr_ram #(.Width(qsr_pkg::REC_W), .Depth(N)) u_store (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  qsr_ram #(.Width(SW), .Depth(N)) u_stack (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (k_waddr),
    .wdata_i (k_wdata),
    .raddr_i (k_raddr),
    .rdata_o (k_rdata)
  );

  assign rd_rec   = qsr_pkg::rec_t'(s_rdata);
  assign cnt_m1   = cnt_q - CW'(1);
  assign sp_m1    = sp_q - CW'(1);
  assign left_ok  = {1'b0, a_q} >= ({1'b0, lo_q} + (IW + 1)'(2));
  assign right_ok = ({1'b0, a_q} + (IW + 1)'(2)) <= {1'b0, hi_q};

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    sp_d     = sp_q;
    ovf_d    = ovf_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    a_d      = a_q;
    b_d      = b_q;
    idx_d    = idx_q;
    piv_d    = piv_q;
    strobe_d = 1'b0;
    last_d   = 1'b0;
    trunc_d  = trunc_q;
    s_we     = 1'b0;
    s_waddr  = a_q;
    s_wdata  = s_rdata;
    s_raddr  = b_q;
    k_we     = 1'b0;
    k_waddr  = sp_q[IW-1:0];
    k_wdata  = {lo_q, hi_q};
    k_raddr  = sp_m1[IW-1:0];
    unique case (state_q)
      ST_LOAD: begin
        if (start) begin
          if (cnt_q < CW'(N)) begin
            s_we    = 1'b1;
            s_waddr = cnt_q[IW-1:0];
            s_wdata = {key_i, payload_i};
            cnt_d   = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) begin
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        if (cnt_q >= CW'(2)) begin
          k_we    = 1'b1;
          k_waddr = '0;
          k_wdata = {IW'(0), cnt_m1[IW-1:0]};
          sp_d    = CW'(1);
          state_d = ST_POP;
        end else begin
          idx_d   = '0;
          state_d = ST_EMIT;
        end
      end
      ST_POP: begin
        if (sp_q == '0) begin
          idx_d   = '0;
          state_d = ST_EMIT;
        end else begin
          sp_d    = sp_m1;
          state_d = ST_POPW;
        end
      end
      ST_POPW: begin
        lo_d    = k_rdata[SW-1:IW];
        hi_d    = k_rdata[IW-1:0];
        a_d     = k_rdata[SW-1:IW];
        b_d     = k_rdata[IW-1:0];
        s_raddr = k_rdata[SW-1:IW];
        state_d = ST_PIV;
      end
      ST_PIV: begin
        piv_d   = rd_rec;
        s_raddr = b_q;
        state_d = ST_SCANB;
      end
      ST_SCANB: begin
        if (a_q >= b_q) begin
          state_d = ST_PLACE;
        end else if (rd_rec.key >= piv_q.key) begin
          b_d     = b_q - IW'(1);
          s_raddr = b_q - IW'(1);
        end else begin
          s_we    = 1'b1;
          s_waddr = a_q;
          a_d     = a_q + IW'(1);
          s_raddr = a_q + IW'(1);
          state_d = ST_SCANA;
        end
      end
      ST_SCANA: begin
        if (a_q >= b_q) begin
          state_d = ST_PLACE;
        end else if (rd_rec.key <= piv_q.key) begin
          a_d     = a_q + IW'(1);
          s_raddr = a_q + IW'(1);
        end else begin
          s_we    = 1'b1;
          s_waddr = b_q;
          b_d     = b_q - IW'(1);
          s_raddr = b_q - IW'(1);
          state_d = ST_SCANB;
        end
      end
      ST_PLACE: begin
        s_we    = 1'b1;
        s_waddr = a_q;
        s_wdata = piv_q;
        if (left_ok) begin
          k_we    = 1'b1;
          k_wdata = {lo_q, a_q - IW'(1)};
          sp_d    = sp_q + CW'(1);
        end
        state_d = ST_PUSHR;
      end
      ST_PUSHR: begin
        if (right_ok) begin
          k_we    = 1'b1;
          k_wdata = {a_q + IW'(1), hi_q};
          sp_d    = sp_q + CW'(1);
        end
        state_d = ST_POP;
      end
      ST_EMIT: begin
        s_raddr  = idx_q;
        strobe_d = 1'b1;
        trunc_d  = ovf_q;
        if (CW'({1'b0, idx_q}) == cnt_m1) begin
          last_d  = 1'b1;
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_LOAD;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      cnt_q    <= '0;
      sp_q     <= '0;
      ovf_q    <= 1'b0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      trunc_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      sp_q     <= sp_d;
      ovf_q    <= ovf_d;
      strobe_q <= strobe_d;
      last_q   <= last_d;
      trunc_q  <= trunc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    a_q   <= a_d;
    b_q   <= b_d;
    idx_q <= idx_d;
    piv_q <= piv_d;
  end

  assign busy          = (state_q != ST_LOAD);
  assign strobe_o      = strobe_q;
  assign key_res_o     = rd_rec.key;
  assign payload_res_o = rd_rec.payload;
  assign last_res_o    = last_q;
  assign truncated_o   = trunc_q;

  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(busy))
    else $error("result strobe without a preceding sort");

  a_last_has_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_res_o |-> strobe_o)
    else $error("last flag outside a result cycle");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= CW'(N))
    else $error("range stack overrun");

  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCANB || state_q == ST_SCANA) |-> (a_q <= b_q))
    else $error("partition pointers crossed");

  a_idle_stack_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (sp_q == '0))
    else $error("range stack not empty while idle");

endmodule

>>> tb/tb_quick_sort_records.sv
// Self-checking testbench for the record sorter: queued batches in, sorted records checked out.
`timescale 1ns / 100ps

module tb_quick_sort_records;

  localparam int CAP         = 64;
  localparam int ITEM_TARGET = 330;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 40;

  typedef enum int {KEYS_WIDE, KEYS_NARROW, KEYS_RISING, KEYS_FALLING} key_mix_e;

  typedef struct packed {
    qsr_pkg::rec_t rec;
    logic last;
  } request_t;

  typedef struct packed {
    qsr_pkg::rec_t rec;
    logic last;
    logic trunc;
  } sorted_rec_t;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               start     = 1'b0;
  logic signed [31:0] key_i     = '0;
  logic        [7:0]  payload_i = '0;
  logic               last_i    = 1'b0;
  logic               busy;
  logic               strobe_o;
  logic signed [31:0] key_res_o;
  logic        [7:0]  payload_res_o;
  logic               last_res_o;
  logic               truncated_o;

  request_t    request_q[$];
  sorted_rec_t sorted_q[$];

  qsr_pkg::rec_t batch_store[CAP];
  int   batch_count   = 0;
  bit   batch_dropped = 1'b0;

  bit req_taken     = 1'b0;
  int items_queued  = 0;
  int items_sent    = 0;
  int batches_seen  = 0;
  int records_seen  = 0;
  int trunc_batches = 0;
  int error_count   = 0;
  int cycle_count   = 0;

  quick_sort_records #(.N(CAP)) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .key_i        (key_i),
    .payload_i    (payload_i),
    .last_i       (last_i),
    .strobe_o     (strobe_o),
    .key_res_o    (key_res_o),
    .payload_res_o(payload_res_o),
    .last_res_o   (last_res_o),
    .truncated_o  (truncated_o)
  );

  always #1 clk_i = ~clk_i;

  task automatic report_error(string msg);
    error_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Store one accepted request; on last, sort the batch and queue the sorted records.
  task automatic load_record(qsr_pkg::rec_t r, logic last);
    int span_lo[CAP+1];
    int span_hi[CAP+1];
    int sp, lo, hi, a, b;
    qsr_pkg::rec_t piv;
    sorted_rec_t s;
    if (batch_count < CAP) begin
      batch_store[batch_count] = r;
      batch_count++;
    end else begin
      batch_dropped = 1'b1;
    end
    if (!last) return;
    sp = 0;
    span_lo[sp] = 0;
    span_hi[sp] = batch_count - 1;
    sp++;
    while (sp > 0) begin
      sp--;
      lo = span_lo[sp];
      hi = span_hi[sp];
      if (lo < 0 || hi >= CAP || lo >= hi) continue;
      a = lo;
      b = hi;
      piv = batch_store[lo];
      while (a < b) begin
        while (a < b && $signed(batch_store[b].key) >= $signed(piv.key)) b--;
        if (a < b) begin
          batch_store[a] = batch_store[b];
          a++;
        end
        while (a < b && $signed(batch_store[a].key) <= $signed(piv.key)) a++;
        if (a < b) begin
          batch_store[b] = batch_store[a];
          b--;
        end
      end
      batch_store[a] = piv;
      if (sp < CAP + 1) begin
        span_lo[sp] = lo;
        span_hi[sp] = a - 1;
        sp++;
      end
      if (sp < CAP + 1) begin
        span_lo[sp] = a + 1;
        span_hi[sp] = hi;
        sp++;
      end
    end
    for (int k = 0; k < batch_count; k++) begin
      s.rec   = batch_store[k];
      s.last  = (k == batch_count - 1);
      s.trunc = batch_dropped;
      sorted_q.push_back(s);
    end
    batch_count   = 0;
    batch_dropped = 1'b0;
  endtask

  task automatic queue_request(logic signed [31:0] key, logic [7:0] payload, logic last);
    request_t q;
    q.rec.key     = key;
    q.rec.payload = payload;
    q.last        = last;
    request_q.push_back(q);
    items_queued++;
  endtask

  task automatic queue_batch(int n, key_mix_e mix);
    logic signed [31:0] k;
    k = $signed($urandom_range(0, 2000)) - 1000;
    for (int i = 0; i < n; i++) begin
      case (mix)
        KEYS_WIDE:    k = $urandom;
        KEYS_NARROW:  k = $signed($urandom_range(0, 7)) - 4;
        KEYS_RISING:  k = k + $urandom_range(0, 3);
        KEYS_FALLING: k = k - $urandom_range(0, 3);
        default:      k = $urandom;
      endcase
      queue_request(k, 8'($urandom), i == n - 1);
    end
  endtask

  // Present requests at the falling edge; hold one until it is taken.
  always @(negedge clk_i) begin
    logic     start_n;
    request_t q;
    int       idle_pct;
    start_n = start;
    if (rst_ni) begin
      idle_pct = (items_sent < 110) ? 6 : (items_sent < 220) ? 81 : 0;
      if (start && !req_taken) begin
        start_n = 1'b1;
      end else if (request_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        q = request_q.pop_front();
        items_sent++;
        start_n = 1'b1;
        key_i     <= q.rec.key;
        payload_i <= q.rec.payload;
        last_i    <= q.last;
      end else begin
        start_n = 1'b0;
      end
    end
    start <= start_n;
  end

  // Sample at the rising edge: check results, then predict for a taken request.
  always @(posedge clk_i) begin
    sorted_rec_t s;
    qsr_pkg::rec_t r;
    req_taken <= rst_ni && start && !busy;
    if (rst_ni && strobe_o) begin
      if (sorted_q.size() == 0) begin
        report_error($sformatf("unexpected result key %0d payload %0d",
                               key_res_o, payload_res_o));
      end else begin
        s = sorted_q.pop_front();
        records_seen++;
        if (key_res_o !== s.rec.key)
          report_error($sformatf("record %0d key: got %0d expected %0d",
                                 records_seen, key_res_o, $signed(s.rec.key)));
        if (payload_res_o !== s.rec.payload)
          report_error($sformatf("record %0d payload: got %0d expected %0d",
                                 records_seen, payload_res_o, s.rec.payload));
        if (last_res_o !== s.last)
          report_error($sformatf("record %0d last: got %b expected %b",
                                 records_seen, last_res_o, s.last));
        if (truncated_o !== s.trunc)
          report_error($sformatf("record %0d truncated: got %b expected %b",
                                 records_seen, truncated_o, s.trunc));
        if (s.last) begin
          batches_seen++;
          if (s.trunc) trunc_batches++;
        end
      end
    end
    if (rst_ni && start && !busy) begin
      r.key     = key_i;
      r.payload = payload_i;
      load_record(r, last_i);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d records outstanding", cycle_count,
               sorted_q.size());
      $display("quick_sort_records regression: fail");
      $finish;
    end
  end

  initial begin
    int n;
    // single record, extreme key
    queue_request(32'sh8000_0000, 8'hFF, 1'b1);
    // two records, reversed extremes
    queue_request(32'sh7FFF_FFFF, 8'h00, 1'b0);
    queue_request(32'sh8000_0000, 8'hFF, 1'b1);
    // mixed extremes
    queue_request(32'sh0000_0000, 8'h00, 1'b0);
    queue_request(-32'sd1, 8'hFF, 1'b0);
    queue_request(32'sh7FFF_FFFF, 8'hAA, 1'b0);
    queue_request(32'sh8000_0000, 8'h55, 1'b0);
    queue_request(32'sd1, 8'h01, 1'b1);
    // equal keys keep the partition order
    for (int i = 0; i < 4; i++) queue_request(32'sd7, 8'(i + 1), i == 3);
    // already ordered and reverse ordered
    for (int i = 0; i < 6; i++) queue_request(32'(i * 3 - 5), 8'(i), i == 5);
    for (int i = 0; i < 6; i++) queue_request(32'(20 - i * 4), 8'(i + 16), i == 5);
    // store full, dropped request carries last
    queue_batch(CAP + 1, KEYS_WIDE);
    while (items_queued < ITEM_TARGET) begin
      if (items_queued > 180 && items_queued < 200) begin
        // store full with two dropped records, the second one carrying last
        queue_batch(CAP + 2, KEYS_NARROW);
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, CAP) : $urandom_range(1, 12);
        queue_batch(n, key_mix_e'($urandom_range(0, 3)));
      end
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (request_q.size() != 0 || start || sorted_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("sent %0d requests in %0d batches, %0d sorted records checked",
             items_sent, batches_seen, records_seen);
    $display("%0d batches overflowed the store, %0d errors", trunc_batches, error_count);
    if (error_count == 0) begin
      $display("quick_sort_records regression: pass");
    end else begin
      $display("quick_sort_records regression: fail");
    end
    $finish;
  end

endmodule

>>> quick_sort_records.f
hdl/qsr_pkg.sv
hdl/qsr_ram.sv
hdl/quick_sort_records.sv
tb/tb_quick_sort_records.sv
